[src/relation_property_checker_core_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the relation property checker
// Shorthand for clocked implication checks with a synchronous reset.
// ----------------------------------------------------------------------------
`ifndef RELATION_PROPERTY_CHECKER_CORE_ASSERT_SVH
`define RELATION_PROPERTY_CHECKER_CORE_ASSERT_SVH

// Same-cycle implication: whenever cond holds, prop holds on that edge.
`define RPC_ASSERT_IMPL(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error(msg);

// Next-cycle implication: whenever cond holds, prop holds on the next edge.
`define RPC_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error(msg);

`endif

[src/rpc_pkg.sv]
// ----------------------------------------------------------------------------
// Relation property checker package
// Shared widths, defaults and the result flag layout.
// ----------------------------------------------------------------------------
package rpc_pkg;

   // Element ids arrive as 4-bit values on the request channel.
   localparam int ID_WIDTH             = 4;
   localparam int ID_SPAN              = 1 << ID_WIDTH;
   localparam int NUM_ELEMENTS_DEFAULT = 16;

   localparam int REQ_DATA_WIDTH = 8;
   localparam int RSP_DATA_WIDTH = 8;

   // Result flags, reflexive in the lowest bit.
   typedef struct packed {
      logic transitive;
      logic antisymmetric;
      logic symmetric;
      logic reflexive;
   } rpc_flags_type;

   localparam int FLAGS_WIDTH = $bits(rpc_flags_type);

endpackage

[src/relation_property_checker_core.sv]
// ----------------------------------------------------------------------------
// Relation property checker core
// Loads a base set and a binary relation beat by beat, then reports whether
// the relation is reflexive, symmetric, antisymmetric and transitive.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Payload                                  | Handshake
//  --------+-----------+------------------------------------------+--------------
//  req     | in        | tdata first/second elem, tuser kind,     | tvalid/tready
//          |           | tlast closes the relation                |
//  rsp     | out       | tdata four property flags                | tvalid/tready
//
//  Loading takes one beat per cycle, including pairs that hit the same row
//  back to back (a one-deep write buffer forwards the pending row).
//  The closing beat (tlast) is followed by the flush state, the scan and the
//  drain state before rsp_tvalid rises, ROWS being min(NUM_ELEMENTS, 16);
//  the scan visits all ROWS*ROWS (row a, row b) pairs, one a cycle, through
//  the two read ports of the relation memory and one shared compare unit.
//  Reset is synchronous; per-row valid bits and the member mask clear at
//  once, so no clearing pass follows reset.
//  The flags sit in an output register, so the next run loads while a result
//  beat waits; only a drain that finds that register still full holds until
//  rsp_tready takes the older beat.
//
// ----------------------------------------------------------------------------
`include "relation_property_checker_core_assert.svh"

module relation_property_checker_core #(
   parameter int NUM_ELEMENTS = rpc_pkg::NUM_ELEMENTS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   // Request channel.
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [rpc_pkg::REQ_DATA_WIDTH-1:0] req_tdata,  // [3:0] first_elem, [7:4] second_elem
   input  logic                               req_tuser,  // [0] kind
   input  logic                               req_tlast,
   // Result channel.
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [rpc_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata   // [0] reflexive, [1] symmetric,
                                                          // [2] antisymmetric, [3] transitive
);

   import rpc_pkg::*;

   // Ids are only 4 bits wide, so rows and columns past 15 can never be set
   // and are left out of storage and of the scan.
   localparam int ROWS = (NUM_ELEMENTS < ID_SPAN) ? NUM_ELEMENTS : ID_SPAN;
   localparam int RW   = $clog2(ROWS);

   localparam logic [ID_WIDTH:0] IdLimit = (ID_WIDTH + 1)'(ROWS);
   localparam logic [RW-1:0]     LastIdx = RW'(ROWS - 1);

   localparam logic [2:0] ST_LOAD   = 3'd0;
   localparam logic [2:0] ST_FLUSH  = 3'd1;
   localparam logic [2:0] ST_SCAN   = 3'd2;
   localparam logic [2:0] ST_DRAIN  = 3'd3;

   // Request decode.
   logic [ID_WIDTH-1:0] first_elem;
   logic [ID_WIDTH-1:0] second_elem;
   logic                req_accept;
   logic                pair_ok;
   logic                member_ok;

   // Control state.
   logic [2:0]    state_ff, state_in;
   logic [RW-1:0] a_ff, a_in;
   logic [RW-1:0] b_ff, b_in;
   logic          eval_vld_ff, eval_vld_in;
   logic [RW-1:0] ea_ff, eb_ff;
   rpc_flags_type flags_ff, flags_in;

   // Result register.
   logic          rsp_vld_ff, rsp_vld_in;
   rpc_flags_type rsp_flags_ff, rsp_flags_in;

   // Stores.
   logic [ROWS-1:0] mem [ROWS];
   logic [ROWS-1:0] row_vld_ff, row_vld_in;
   logic [ROWS-1:0] mask_ff, mask_in;
   logic [ROWS-1:0] rd0_ff, rd1_ff;
   logic            rv0_ff, rv1_ff;
   logic [RW-1:0]   rd0_addr;

   // Pending row update and forwarding.
   logic            p_vld_ff, p_vld_in;
   logic [RW-1:0]   p_row_ff;
   logic [RW-1:0]   p_col_ff;
   logic            fwd_ff, fwd_in;
   logic [ROWS-1:0] fwd_data_ff;
   logic [ROWS-1:0] old_row;
   logic [ROWS-1:0] new_row;

   // Shared compare unit.
   logic [ROWS-1:0] row_a;
   logic [ROWS-1:0] row_b;
   logic            bit_ab;
   logic            bit_ba;
   logic            same;
   rpc_flags_type   fail;

   assign first_elem  = req_tdata[ID_WIDTH-1:0];
   assign second_elem = req_tdata[2*ID_WIDTH-1:ID_WIDTH];
   assign req_tready  = (state_ff == ST_LOAD);
   assign req_accept  = req_tvalid && req_tready;
   assign member_ok   = req_accept && !req_tuser && ({1'b0, first_elem} < IdLimit);
   assign pair_ok     = req_accept && req_tuser && ({1'b0, first_elem} < IdLimit) &&
                        ({1'b0, second_elem} < IdLimit);

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {(RSP_DATA_WIDTH - FLAGS_WIDTH)'(0), rsp_flags_ff};

   // The row read in the accept cycle may be stale if the previous pair
   // wrote the same row on that very edge; the forwarded copy covers it.
   always_comb begin
      if (fwd_ff) begin
         old_row = fwd_data_ff;
      end else if (rv0_ff) begin
         old_row = rd0_ff;
      end else begin
         old_row = '0;
      end
      new_row = old_row | (ROWS'(1) << p_col_ff);
   end

   assign p_vld_in = pair_ok;
   assign fwd_in   = pair_ok && p_vld_ff && (p_row_ff == first_elem[RW-1:0]);
   assign rd0_addr = (state_ff == ST_LOAD) ? first_elem[RW-1:0] : a_ff;

   // Compare unit: one (a, b) cell of the relation per cycle.
   always_comb begin
      row_a   = rv0_ff ? rd0_ff : '0;
      row_b   = rv1_ff ? rd1_ff : '0;
      bit_ab  = row_a[eb_ff];
      bit_ba  = row_b[ea_ff];
      same    = (ea_ff == eb_ff);
      fail.reflexive     = same && mask_ff[ea_ff] && !bit_ab;
      fail.symmetric     = bit_ab && !bit_ba;
      fail.antisymmetric = !same && bit_ab && bit_ba;
      fail.transitive    = bit_ab && ((row_b & ~row_a) != '0);
   end

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      eval_vld_in  = 1'b0;
      flags_in     = flags_ff;
      row_vld_in   = row_vld_ff;
      mask_in      = mask_ff;
      rsp_vld_in   = rsp_vld_ff;
      rsp_flags_in = rsp_flags_ff;

      if (member_ok) begin
         mask_in[first_elem[RW-1:0]] = 1'b1;
      end
      if (p_vld_ff) begin
         row_vld_in[p_row_ff] = 1'b1;
      end
      if (eval_vld_ff) begin
         flags_in = flags_ff & ~fail;
      end
      if (rsp_vld_ff && rsp_tready) begin
         rsp_vld_in = 1'b0;
      end

      case (state_ff)
         ST_LOAD: begin
            if (req_accept && req_tlast) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            // The last pending row lands in memory at the end of this cycle.
            a_in     = '0;
            b_in     = '0;
            flags_in = '1;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            eval_vld_in = 1'b1;
            if (b_ff == LastIdx) begin
               b_in = '0;
               if (a_ff == LastIdx) begin
                  a_in     = '0;
                  state_in = ST_DRAIN;
               end else begin
                  a_in = a_ff + RW'(1);
               end
            end else begin
               b_in = b_ff + RW'(1);
            end
         end
         ST_DRAIN: begin
            // The final cell is evaluated in the first drain cycle; both
            // stores empty for the next run. The flags move out as soon as
            // the result register is free.
            row_vld_in = '0;
            mask_in    = '0;
            if (!rsp_vld_ff || rsp_tready) begin
               rsp_vld_in   = 1'b1;
               rsp_flags_in = flags_in;
               state_in     = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         a_ff         <= '0;
         b_ff         <= '0;
         eval_vld_ff  <= 1'b0;
         flags_ff     <= '1;
         row_vld_ff   <= '0;
         mask_ff      <= '0;
         p_vld_ff     <= 1'b0;
         fwd_ff       <= 1'b0;
         rsp_vld_ff   <= 1'b0;
         rsp_flags_ff <= '0;
      end else begin
         state_ff     <= state_in;
         a_ff         <= a_in;
         b_ff         <= b_in;
         eval_vld_ff  <= eval_vld_in;
         flags_ff     <= flags_in;
         row_vld_ff   <= row_vld_in;
         mask_ff      <= mask_in;
         p_vld_ff     <= p_vld_in;
         fwd_ff       <= fwd_in;
         rsp_vld_ff   <= rsp_vld_in;
         rsp_flags_ff <= rsp_flags_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      p_row_ff    <= first_elem[RW-1:0];
      p_col_ff    <= second_elem[RW-1:0];
      fwd_data_ff <= new_row;
      ea_ff       <= a_ff;
      eb_ff       <= b_ff;
   end

   // Relation memory: one write port, two registered read ports.
   always_ff @(posedge clock) begin
      if (p_vld_ff) begin
         mem[p_row_ff] <= new_row;
      end
      rd0_ff <= mem[rd0_addr];
      rd1_ff <= mem[b_ff];
      rv0_ff <= row_vld_ff[rd0_addr];
      rv1_ff <= row_vld_ff[b_ff];
   end

   // Checks.
   `RPC_ASSERT_NEXT(a_result_held, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata), "waiting result beat changed")
   `RPC_ASSERT_NEXT(a_last_starts_flush, clock, reset, req_accept && req_tlast,
      state_ff == ST_FLUSH, "closing beat did not start the flush cycle")
   `RPC_ASSERT_NEXT(a_drain_clears_stores, clock, reset, state_ff == ST_DRAIN,
      (mask_ff == '0) && (row_vld_ff == '0), "stores not cleared by the drain cycle")
   `RPC_ASSERT_IMPL(a_eval_in_scan, clock, reset, eval_vld_ff,
      (state_ff == ST_SCAN) || (state_ff == ST_DRAIN), "compare unit active outside the scan")

endmodule

[tb/sv/relation_property_checker_core_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Relation property checker core testbench
// Streams member and pair beats into the core and checks each flag beat
// against a bit-matrix predictor of the four relation properties.
// ----------------------------------------------------------------------------

// One request beat as the predictor sees it.
typedef enum bit {
   KIND_MEMBER = 1'b0,
   KIND_PAIR   = 1'b1
} beat_kind_type;

typedef struct packed {
   beat_kind_type kind;
   logic [3:0]    first_elem;
   logic [3:0]    second_elem;
   logic          last;
} relation_beat_type;

// Keeps its own copy of the relation and the base set, predicts the flag
// beat for every closing request and compares the core's flag beats in order.
class relation_scoreboard;
   localparam int SPAN = rpc_pkg::NUM_ELEMENTS_DEFAULT;

   bit [SPAN-1:0]          relation_rows [SPAN];
   bit [SPAN-1:0]          member_bits;
   rpc_pkg::rpc_flags_type pending_flags [$];
   int                     failures;
   int                     flags_checked;
   int                     beats_noted;

   function int outstanding();
      return pending_flags.size();
   endfunction

   function void flag_failure(string what);
      failures++;
      if (failures <= 10) begin
         $display("[%0t] mismatch: %s", $realtime, what);
      end
   endfunction

   // Works out the four properties from the current stores.
   function rpc_pkg::rpc_flags_type evaluate_relation();
      rpc_pkg::rpc_flags_type flags;
      flags = '1;
      for (int i = 0; i < SPAN; i++) begin
         if (member_bits[i] && !relation_rows[i][i]) begin
            flags.reflexive = 1'b0;
         end
         for (int j = 0; j < SPAN; j++) begin
            if (relation_rows[i][j]) begin
               if (!relation_rows[j][i]) begin
                  flags.symmetric = 1'b0;
               end
               if (i != j && relation_rows[j][i]) begin
                  flags.antisymmetric = 1'b0;
               end
               // Everything reachable from j must already be reachable from i.
               if ((relation_rows[j] & ~relation_rows[i]) != '0) begin
                  flags.transitive = 1'b0;
               end
            end
         end
      end
      return flags;
   endfunction

   function void note_request(relation_beat_type beat);
      beats_noted++;
      if (beat.kind == KIND_MEMBER) begin
         if (beat.first_elem < SPAN) begin
            member_bits[beat.first_elem] = 1'b1;
         end
      end else if (beat.first_elem < SPAN && beat.second_elem < SPAN) begin
         relation_rows[beat.first_elem][beat.second_elem] = 1'b1;
      end
      if (beat.last) begin
         pending_flags.push_back(evaluate_relation());
         member_bits = '0;
         foreach (relation_rows[i]) begin
            relation_rows[i] = '0;
         end
      end
   endfunction

   function void compare_flag(string name, logic want, logic got);
      if (want !== got) begin
         flag_failure($sformatf("flag beat %0d, %s expected %0b got %0b",
                                flags_checked, name, want, got));
      end
   endfunction

   function void check_result(logic [rpc_pkg::RSP_DATA_WIDTH-1:0] data);
      rpc_pkg::rpc_flags_type want;
      rpc_pkg::rpc_flags_type got;
      if (pending_flags.size() == 0) begin
         flag_failure($sformatf("flag beat %0d (data %h) arrived with none expected",
                                flags_checked, data));
         flags_checked++;
         return;
      end
      want = pending_flags.pop_front();
      got  = data[rpc_pkg::FLAGS_WIDTH-1:0];
      compare_flag("reflexive", want.reflexive, got.reflexive);
      compare_flag("symmetric", want.symmetric, got.symmetric);
      compare_flag("antisymmetric", want.antisymmetric, got.antisymmetric);
      compare_flag("transitive", want.transitive, got.transitive);
      if (data[rpc_pkg::RSP_DATA_WIDTH-1:rpc_pkg::FLAGS_WIDTH] !== '0) begin
         flag_failure($sformatf("flag beat %0d, padding expected 0 got %h",
                                flags_checked,
                                data[rpc_pkg::RSP_DATA_WIDTH-1:rpc_pkg::FLAGS_WIDTH]));
      end
      flags_checked++;
   endfunction
endclass

module relation_property_checker_core_test;

   // Cycles in a row with no beat accepted on either side before giving up.
   // The closing beat alone holds the core through its flush, scan and drain,
   // and a sender gap plus a receiver stall can add to that.
   localparam int STALL_LIMIT  = 2000;
   // Cycles to watch for stray flag beats once everything has arrived.
   localparam int TAIL_CYCLES  = 300;
   localparam int RANDOM_BEATS = 500;
   // From here on neither side idles.
   localparam int CALM_FROM    = 420;

   typedef enum int {
      SHAPE_SCATTER,
      SHAPE_MIRRORED,
      SHAPE_EQUIVALENCE,
      SHAPE_CHAIN,
      SHAPE_NOISE
   } frame_shape_type;

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               req_tvalid = 1'b0;
   logic                               req_tready;
   logic [rpc_pkg::REQ_DATA_WIDTH-1:0] req_tdata = '0;  // [3:0] first_elem, [7:4] second_elem
   logic                               req_tuser = 1'b0;  // [0] kind
   logic                               req_tlast = 1'b0;
   logic                               rsp_tvalid;
   logic                               rsp_tready = 1'b0;
   logic [rpc_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata;  // [0] reflexive, [1] symmetric,
                                                   // [2] antisymmetric, [3] transitive

   relation_scoreboard sb = new();
   relation_beat_type  frame_beats [$];
   bit                 idling_on = 1'b1;
   int                 stall_left = 0;
   int                 quiet_cycles = 0;
   int                 beats_sent = 0;
   int                 frames_sent = 0;

   relation_property_checker_core #(
      .NUM_ELEMENTS(rpc_pkg::NUM_ELEMENTS_DEFAULT)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .req_tlast (req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // The receiver stalls in random bursts while idling is on.
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (idling_on && $urandom_range(0, 9) == 0) begin
         stall_left = $urandom_range(1, 18) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Monitor: both channels are sampled at the rising edge, before the core's
   // registers move, so the values seen are the ones the handshake used.
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            sb.note_request('{kind:        beat_kind_type'(req_tuser),
                              first_elem:  req_tdata[3:0],
                              second_elem: req_tdata[7:4],
                              last:        req_tlast});
         end
         if (rsp_tvalid && rsp_tready) begin
            sb.check_result(rsp_tdata);
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Timeout: no beat moved for %0d cycles", STALL_LIMIT);
            $display("FAILURE");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   function automatic relation_beat_type make_beat(beat_kind_type kind, logic [3:0] first_elem,
                                                   logic [3:0] second_elem, logic last);
      relation_beat_type beat;
      beat.kind        = kind;
      beat.first_elem  = first_elem;
      beat.second_elem = second_elem;
      beat.last        = last;
      return beat;
   endfunction

   // Offers one request beat, optionally after a random gap, and returns once
   // the core has taken it.
   task automatic send_beat(relation_beat_type beat);
      int gap;
      gap = 0;
      if (idling_on && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 18);
      end
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= beat.kind;
      req_tdata  <= {beat.second_elem, beat.first_elem};
      req_tlast  <= beat.last;
      do @(posedge clock); while (!req_tready);
      beats_sent++;
   endtask

   // Holds the request side quiet until every flag beat owed has come back.
   task automatic drain_results();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (sb.outstanding() != 0) @(negedge clock);
   endtask

   // Builds one frame into frame_beats. Most frames are well formed: a small
   // group of ids with members and pairs that tend to make some properties
   // hold, sometimes with one beat dropped so that they just fail. Noise
   // frames use any field values and may close more than once.
   task automatic build_frame();
      frame_shape_type   shape;
      logic [3:0]        group_ids [$];
      logic [3:0]        base_id;
      int                group_size;
      int                count;
      int                pick;
      relation_beat_type held;
      shape      = frame_shape_type'($urandom_range(0, 4));
      base_id    = 4'($urandom_range(0, 15));
      group_size = $urandom_range(1, 4);
      frame_beats.delete();
      group_ids.delete();
      for (int k = 0; k < group_size; k++) begin
         group_ids.push_back(base_id + 4'(k));
      end
      case (shape)
         SHAPE_SCATTER: begin
            count = $urandom_range(1, 10);
            for (int k = 0; k < count; k++) begin
               frame_beats.push_back(make_beat(beat_kind_type'($urandom_range(0, 1)),
                                     group_ids[$urandom_range(0, group_size - 1)],
                                     group_ids[$urandom_range(0, group_size - 1)], 1'b0));
            end
         end
         SHAPE_MIRRORED: begin
            count = $urandom_range(1, 5);
            for (int k = 0; k < count; k++) begin
               held = make_beat(KIND_PAIR, group_ids[$urandom_range(0, group_size - 1)],
                                group_ids[$urandom_range(0, group_size - 1)], 1'b0);
               frame_beats.push_back(held);
               frame_beats.push_back(make_beat(KIND_PAIR, held.second_elem,
                                               held.first_elem, 1'b0));
            end
            if ($urandom_range(0, 1) == 0) begin
               frame_beats.push_back(make_beat(KIND_MEMBER, group_ids[0],
                                               4'($urandom_range(0, 15)), 1'b0));
               frame_beats.push_back(make_beat(KIND_PAIR, group_ids[0], group_ids[0], 1'b0));
            end
         end
         SHAPE_EQUIVALENCE, SHAPE_CHAIN: begin
            // Equivalence: every pair in the group. Chain: a total order on it.
            for (int i = 0; i < group_size; i++) begin
               frame_beats.push_back(make_beat(KIND_MEMBER, group_ids[i],
                                               4'($urandom_range(0, 15)), 1'b0));
               for (int j = 0; j < group_size; j++) begin
                  if (shape == SHAPE_EQUIVALENCE || i <= j) begin
                     frame_beats.push_back(make_beat(KIND_PAIR, group_ids[i],
                                                     group_ids[j], 1'b0));
                  end
               end
            end
         end
         default: begin
            count = $urandom_range(1, 12);
            for (int k = 0; k < count; k++) begin
               frame_beats.push_back(make_beat(beat_kind_type'($urandom_range(0, 1)),
                                     4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                                     logic'($urandom_range(0, 7) == 0)));
            end
         end
      endcase
      if (shape != SHAPE_NOISE && frame_beats.size() > 1 && $urandom_range(0, 3) == 0) begin
         frame_beats.delete($urandom_range(0, frame_beats.size() - 1));
      end
      // Order within a frame does not matter to the core, so mix it up.
      for (int k = frame_beats.size() - 1; k > 0; k--) begin
         pick              = $urandom_range(0, k);
         held              = frame_beats[k];
         frame_beats[k]    = frame_beats[pick];
         frame_beats[pick] = held;
      end
      frame_beats[frame_beats.size() - 1].last = 1'b1;
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed frames.
      // A set with an empty relation: not reflexive, everything else holds.
      send_beat(make_beat(KIND_MEMBER, 4'd0, 4'd0, 1'b1));
      // An empty set with a self pair: all four hold.
      send_beat(make_beat(KIND_PAIR, 4'd3, 4'd3, 1'b1));
      // A member carries a second id that must be ignored.
      send_beat(make_beat(KIND_MEMBER, 4'd5, 4'd15, 1'b1));
      // The extreme ids related both ways with their self pairs.
      send_beat(make_beat(KIND_MEMBER, 4'd15, 4'd0, 1'b0));
      send_beat(make_beat(KIND_PAIR, 4'd15, 4'd15, 1'b0));
      send_beat(make_beat(KIND_MEMBER, 4'd0, 4'd15, 1'b0));
      send_beat(make_beat(KIND_PAIR, 4'd0, 4'd0, 1'b0));
      send_beat(make_beat(KIND_PAIR, 4'd0, 4'd15, 1'b0));
      send_beat(make_beat(KIND_PAIR, 4'd15, 4'd0, 1'b1));
      // A two-step path without its shortcut, with a repeated pair.
      send_beat(make_beat(KIND_PAIR, 4'd1, 4'd2, 1'b0));
      send_beat(make_beat(KIND_PAIR, 4'd2, 4'd3, 1'b0));
      send_beat(make_beat(KIND_PAIR, 4'd1, 4'd2, 1'b1));
      // A small equivalence class loaded with duplicates.
      send_beat(make_beat(KIND_PAIR, 4'd4, 4'd5, 1'b0));
      send_beat(make_beat(KIND_PAIR, 4'd5, 4'd4, 1'b0));
      send_beat(make_beat(KIND_PAIR, 4'd4, 4'd5, 1'b0));
      send_beat(make_beat(KIND_MEMBER, 4'd4, 4'd0, 1'b0));
      send_beat(make_beat(KIND_PAIR, 4'd4, 4'd4, 1'b0));
      send_beat(make_beat(KIND_MEMBER, 4'd5, 4'd0, 1'b0));
      send_beat(make_beat(KIND_PAIR, 4'd5, 4'd5, 1'b1));
      // One-way pair and a member without its self pair.
      send_beat(make_beat(KIND_PAIR, 4'd15, 4'd0, 1'b0));
      send_beat(make_beat(KIND_MEMBER, 4'd15, 4'd0, 1'b1));

      // Let the core fully settle once before the random frames start.
      drain_results();

      while (beats_sent < RANDOM_BEATS) begin
         build_frame();
         foreach (frame_beats[k]) begin
            if (beats_sent >= CALM_FROM) begin
               idling_on = 1'b0;
            end
            send_beat(frame_beats[k]);
         end
         frames_sent++;
         if ($urandom_range(0, 9) == 0) begin
            drain_results();
         end
      end

      drain_results();
      repeat (TAIL_CYCLES) @(negedge clock);

      $display("Covered %0d request beats in %0d random frames plus directed cases,",
               sb.beats_noted, frames_sent);
      $display("with %0d flag beats checked and %0d mismatches.",
               sb.flags_checked, sb.failures);
      if (sb.failures == 0 && sb.outstanding() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

[filelist.f]
+incdir+src
src/rpc_pkg.sv
src/relation_property_checker_core.sv
tb/sv/relation_property_checker_core_test.sv
